[hw/rtl/pngcsc_pkg.sv]
// ============================================================================
// pngcsc_pkg
// Shared constants and helper functions for the PNG chunk stream checker.
// ============================================================================
package pngcsc_pkg;

    // parse phases
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;

    // chunk kinds
    localparam logic [2:0] KIND_IHDR  = 3'd0;
    localparam logic [2:0] KIND_BKGD  = 3'd1;
    localparam logic [2:0] KIND_PHYS  = 3'd2;
    localparam logic [2:0] KIND_TIME  = 3'd3;
    localparam logic [2:0] KIND_ITXT  = 3'd4;
    localparam logic [2:0] KIND_IDAT  = 3'd5;
    localparam logic [2:0] KIND_IEND  = 3'd6;
    localparam logic [2:0] KIND_OTHER = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIG  = 2'd1;
    localparam logic [1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [1:0] ST_UNK_CRIT = 2'd3;

    // chunk type words, big-endian ASCII
    localparam logic [31:0] T_IHDR = 32'h4948_4452;
    localparam logic [31:0] T_BKGD = 32'h624B_4744;
    localparam logic [31:0] T_PHYS = 32'h7048_5973;
    localparam logic [31:0] T_TIME = 32'h7449_4D45;
    localparam logic [31:0] T_ITXT = 32'h6954_5874;
    localparam logic [31:0] T_IDAT = 32'h4944_4154;
    localparam logic [31:0] T_IEND = 32'h4945_4E44;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [2:0] kind_of(input logic [31:0] t);
        logic [2:0] k;
        case (t)
            T_IHDR:  k = KIND_IHDR;
            T_BKGD:  k = KIND_BKGD;
            T_PHYS:  k = KIND_PHYS;
            T_TIME:  k = KIND_TIME;
            T_ITXT:  k = KIND_ITXT;
            T_IDAT:  k = KIND_IDAT;
            T_IEND:  k = KIND_IEND;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/png_chunk_stream_checker.sv]
// ============================================================================
// png_chunk_stream_checker
// PNG signature check, chunk framing, CRC-32 check and IHDR capture.
// ============================================================================
// One byte per request, one request per cycle sustained while the output is
// not stalled. A byte passes through an input register. The chunk parser and
// CRC update act on it from that register and write any chunk result straight
// into the output register, where the result is offered once its last CRC
// byte has been processed. The single-byte CRC update (eight dependent
// shift/xor steps) sets the critical path. After IEND, an unknown critical
// chunk or a bad signature all bytes are dropped until reset.
module png_chunk_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_chunk_kind,
    output logic [1:0]  o_status,
    output logic        o_stream_done,
    output logic [30:0] o_chunk_length,
    output logic [30:0] o_image_width,
    output logic [30:0] o_image_height,
    output logic [7:0]  o_bit_depth,
    output logic [7:0]  o_color_type,
    output logic [7:0]  o_compression_method,
    output logic [7:0]  o_filter_method,
    output logic [7:0]  o_interlace_method
);
    import pngcsc_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    logic [2:0]  r_phase,   n_phase;
    logic [30:0] r_cnt,     n_cnt;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_type,    n_type;
    logic [31:0] r_rcv,     n_rcv;
    logic        r_sig_ok,  n_sig_ok;
    logic        r_halted,  n_halted;
    logic [63:0] r_hdr_f,   n_hdr_f;
    logic [39:0] r_hdr_b,   n_hdr_b;
    logic [63:0] r_stage_f, n_stage_f;
    logic [39:0] r_stage_b, n_stage_b;

    // output stage
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [1:0]  r_status;
    logic        r_done;
    logic [30:0] r_clen;
    logic [63:0] r_o_hdr_f;
    logic [39:0] r_o_hdr_b;

    logic        w_adv;
    logic        w_emit;
    logic [2:0]  w_kind;
    logic [1:0]  w_status;
    logic        w_done;
    logic [30:0] w_clen;
    logic [31:0] w_cnt_inc;
    logic        w_crc_init;
    logic        w_crc_upd;
    logic [31:0] w_crc;
    logic        w_crc_ok;
    logic        w_crit;
    logic [7:0]  b;

    assign b         = r_in_byte;
    assign w_adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_adv;
    assign w_cnt_inc = {1'b0, r_cnt} + 32'd1;

    pngcsc_crc u_crc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_init   (w_crc_init),
        .i_update (w_crc_upd),
        .i_byte   (b),
        .o_crc    (w_crc)
    );

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_type     = r_type;
        n_rcv      = r_rcv;
        n_sig_ok   = r_sig_ok;
        n_halted   = r_halted;
        n_hdr_f    = r_hdr_f;
        n_hdr_b    = r_hdr_b;
        n_stage_f  = r_stage_f;
        n_stage_b  = r_stage_b;
        w_emit     = 1'b0;
        w_kind     = KIND_OTHER;
        w_status   = ST_OK;
        w_done     = 1'b0;
        w_clen     = '0;
        w_crc_init = 1'b0;
        w_crc_upd  = 1'b0;
        w_crc_ok   = 1'b0;
        w_crit     = 1'b0;

        if (w_adv && !r_halted) begin
            case (r_phase)
                PH_SIG: begin
                    if (b != PNG_SIG[r_cnt[2:0]]) begin
                        n_sig_ok = 1'b0;
                    end
                    n_cnt = w_cnt_inc[30:0];
                    if (w_cnt_inc >= 32'd8) begin
                        n_cnt = '0;
                        if (!n_sig_ok) begin
                            n_halted = 1'b1;
                            w_emit   = 1'b1;
                            w_kind   = KIND_OTHER;
                            w_status = ST_BAD_SIG;
                            w_done   = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    n_len = {r_len[23:0], b};
                    n_cnt = w_cnt_inc[30:0];
                    if (w_cnt_inc >= 32'd4) begin
                        n_len[31]  = 1'b0;   // top bit of length is dropped
                        n_cnt      = '0;
                        n_phase    = PH_TYPE;
                        w_crc_init = 1'b1;
                        n_type     = '0;
                        n_stage_f  = '0;
                        n_stage_b  = '0;
                    end
                end
                PH_TYPE: begin
                    w_crc_upd = 1'b1;
                    n_type    = {r_type[23:0], b};
                    n_cnt     = w_cnt_inc[30:0];
                    if (w_cnt_inc >= 32'd4) begin
                        n_cnt   = '0;
                        n_rcv   = '0;
                        n_phase = (r_len != 32'd0) ? PH_DATA : PH_CRC;
                    end
                end
                PH_DATA: begin
                    w_crc_upd = 1'b1;
                    if (r_type == T_IHDR) begin
                        if (r_cnt < 31'd8) begin
                            for (int k = 0; k < 8; k++) begin
                                if (r_cnt[2:0] == 3'(k)) begin
                                    n_stage_f[63-8*k -: 8] = r_stage_f[63-8*k -: 8] | b;
                                end
                            end
                        end else if (r_cnt < 31'd13) begin
                            for (int k = 0; k < 5; k++) begin
                                if (r_cnt[3:0] == 4'(k + 8)) begin
                                    n_stage_b[39-8*k -: 8] = r_stage_b[39-8*k -: 8] | b;
                                end
                            end
                        end
                    end
                    n_cnt = w_cnt_inc[30:0];
                    if (w_cnt_inc >= r_len) begin
                        n_cnt   = '0;
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_rcv = {r_rcv[23:0], b};
                    n_cnt = w_cnt_inc[30:0];
                    if (w_cnt_inc >= 32'd4) begin
                        w_crc_ok = ((w_crc ^ CRC_INIT) == n_rcv);
                        w_kind   = kind_of(r_type);
                        // critical: first type byte has bit 5 clear
                        w_crit   = (w_kind == KIND_OTHER) && !r_type[29];
                        w_status = w_crit ? ST_UNK_CRIT : (w_crc_ok ? ST_OK : ST_CRC_ERR);
                        if (w_kind == KIND_IHDR && w_crc_ok) begin
                            n_hdr_f = r_stage_f;
                            n_hdr_b = r_stage_b;
                        end
                        w_done   = w_crit || (w_kind == KIND_IEND);
                        n_halted = w_done;
                        w_clen   = r_len[30:0];
                        w_emit   = 1'b1;
                        n_phase  = PH_LEN;
                        n_cnt    = '0;
                        n_len    = '0;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SIG;
            r_cnt       <= '0;
            r_len       <= '0;
            r_type      <= '0;
            r_rcv       <= '0;
            r_sig_ok    <= 1'b1;
            r_halted    <= 1'b0;
            r_hdr_f     <= '0;
            r_hdr_b     <= '0;
            r_stage_f   <= '0;
            r_stage_b   <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_type    <= n_type;
            r_rcv     <= n_rcv;
            r_sig_ok  <= n_sig_ok;
            r_halted  <= n_halted;
            r_hdr_f   <= n_hdr_f;
            r_hdr_b   <= n_hdr_b;
            r_stage_f <= n_stage_f;
            r_stage_b <= n_stage_b;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
        end
        if (w_emit) begin
            r_kind    <= w_kind;
            r_status  <= w_status;
            r_done    <= w_done;
            r_clen    <= w_clen;
            r_o_hdr_f <= n_hdr_f;
            r_o_hdr_b <= n_hdr_b;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_chunk_kind         = r_kind;
    assign o_status             = r_status;
    assign o_stream_done        = r_done;
    assign o_chunk_length       = r_clen;
    assign o_image_width        = r_o_hdr_f[62:32];
    assign o_image_height       = r_o_hdr_f[30:0];
    assign o_bit_depth          = r_o_hdr_b[39:32];
    assign o_color_type         = r_o_hdr_b[31:24];
    assign o_compression_method = r_o_hdr_b[23:16];
    assign o_filter_method      = r_o_hdr_b[15:8];
    assign o_interlace_method   = r_o_hdr_b[7:0];

    // no result once parsing has halted
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !w_emit)
        else $error("result produced after halt");

    // a result that ends the stream halts the parser
    a_done_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_done) |=> r_halted)
        else $error("stream_done without halt");

    // signature phase only reports a bad signature
    a_sig_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_phase == PH_SIG) |-> (w_status == ST_BAD_SIG))
        else $error("unexpected status in signature phase");

    // framing counters stay within their field size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN || r_phase == PH_TYPE || r_phase == PH_CRC)
            |-> (r_cnt < 31'd4))
        else $error("byte counter out of range");

    // a result is never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_emit)
        else $error("pending result overwritten");

endmodule

[hw/rtl/pngcsc_crc.sv]
// ============================================================================
// pngcsc_crc
// Running CRC-32 accumulator, one byte per cycle, restartable.
// ============================================================================
module pngcsc_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init,
    input  logic        i_update,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);
    import pngcsc_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_init) begin
            n_crc = CRC_INIT;
        end else if (i_update) begin
            n_crc = crc32_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

[bench/png_chunk_stream_checker_tb.sv]
// ============================================================================
// png_chunk_stream_checker_tb
// Feeds a PNG byte stream (signature, then framed chunks with real or damaged
// CRCs, IHDR captures, lengths with the top bit set, a final IEND or unknown
// critical chunk and bytes past the halt) through the checker under random
// stalls on both sides. Each chunk report is checked against a byte-level
// shadow parser. Reset is applied once, so the bad-signature path is left
// out: a good signature is needed to reach the chunk parser at all.
// ============================================================================
module png_chunk_stream_checker_tb;

    import pngcsc_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic        done;
        logic [30:0] length;
        logic [30:0] width;
        logic [30:0] height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic [7:0]  comp_method;
        logic [7:0]  filter_method;
        logic [7:0]  interlace;
    } t_chunk_report;

    typedef struct {
        logic [7:0]    b;
        bit            typed;
        t_chunk_report rep;
    } t_dir_row;

    localparam int DIR_N = 20;
    localparam int RAND_BYTES = 1250;
    localparam int MAX_SHOWN = 10;

    // zero-length chunk, length top bit set, ancillary type, all-ones CRC
    localparam logic [7:0] DIR_TAIL [12] = '{8'h80, 8'h00, 8'h00, 8'h00,
                                             8'h72, 8'h75, 8'h53, 8'h74,
                                             8'hFF, 8'hFF, 8'hFF, 8'hFF};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_chunk_kind;
    logic [1:0]  o_status;
    logic        o_stream_done;
    logic [30:0] o_chunk_length;
    logic [30:0] o_image_width;
    logic [30:0] o_image_height;
    logic [7:0]  o_bit_depth;
    logic [7:0]  o_color_type;
    logic [7:0]  o_compression_method;
    logic [7:0]  o_filter_method;
    logic [7:0]  o_interlace_method;

    png_chunk_stream_checker i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_data_byte          (i_data_byte),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_chunk_kind         (o_chunk_kind),
        .o_status             (o_status),
        .o_stream_done        (o_stream_done),
        .o_chunk_length       (o_chunk_length),
        .o_image_width        (o_image_width),
        .o_image_height       (o_image_height),
        .o_bit_depth          (o_bit_depth),
        .o_color_type         (o_color_type),
        .o_compression_method (o_compression_method),
        .o_filter_method      (o_filter_method),
        .o_interlace_method   (o_interlace_method)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow parser state
    logic [2:0]  par_phase;
    logic [31:0] par_cnt;
    logic [31:0] par_len;
    logic [31:0] par_type;
    logic [31:0] par_crc;
    logic [31:0] par_rx_crc;
    logic        par_sig_ok;
    logic [63:0] par_hdr_fields;
    logic [39:0] par_hdr_bytes;
    logic        par_halted;
    logic [63:0] par_stg_fields;
    logic [39:0] par_stg_bytes;

    t_chunk_report pending_reports [$];
    t_dir_row      dir_rows [DIR_N];

    int n_bytes_sent;
    int n_fail;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_left;
    bit pressure_req;

    function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        return c;
    endfunction

    function automatic logic [2:0] chunk_kind_of(input logic [31:0] t);
        case (t)
            T_IHDR:  return KIND_IHDR;
            T_BKGD:  return KIND_BKGD;
            T_PHYS:  return KIND_PHYS;
            T_TIME:  return KIND_TIME;
            T_ITXT:  return KIND_ITXT;
            T_IDAT:  return KIND_IDAT;
            T_IEND:  return KIND_IEND;
            default: return KIND_OTHER;
        endcase
    endfunction

    function automatic t_chunk_report make_report(input logic [2:0] k, input logic [1:0] st,
                                                  input logic dn, input logic [30:0] len);
        t_chunk_report r;
        r.kind          = k;
        r.status        = st;
        r.done          = dn;
        r.length        = len;
        r.width         = par_hdr_fields[62:32];
        r.height        = par_hdr_fields[30:0];
        r.bit_depth     = par_hdr_bytes[39:32];
        r.color_type    = par_hdr_bytes[31:24];
        r.comp_method   = par_hdr_bytes[23:16];
        r.filter_method = par_hdr_bytes[15:8];
        r.interlace     = par_hdr_bytes[7:0];
        return r;
    endfunction

    function automatic string fmt_report(input t_chunk_report r);
        return $sformatf({"kind=%0d st=%0d done=%0d len=%0d w=%0d h=%0d ",
                          "bd=%0h ct=%0h cm=%0h fm=%0h im=%0h"},
                         r.kind, r.status, r.done, r.length, r.width, r.height, r.bit_depth,
                         r.color_type, r.comp_method, r.filter_method, r.interlace);
    endfunction

    task automatic parse_reset();
        par_phase      = PH_SIG;
        par_cnt        = '0;
        par_len        = '0;
        par_type       = '0;
        par_crc        = '1;
        par_rx_crc     = '0;
        par_sig_ok     = 1'b1;
        par_hdr_fields = '0;
        par_hdr_bytes  = '0;
        par_halted     = 1'b0;
        par_stg_fields = '0;
        par_stg_bytes  = '0;
    endtask

    // advance the shadow parser by one byte; got is set when a report is due
    task automatic parse_byte(input logic [7:0] b, output bit got, output t_chunk_report rep);
        bit         crc_ok;
        bit         crit;
        logic [2:0] k;
        logic [1:0] st;
        got = 1'b0;
        rep = '0;
        if (par_halted)
            return;
        case (par_phase)
            PH_SIG: begin
                if (b != PNG_SIG[par_cnt[2:0]])
                    par_sig_ok = 1'b0;
                par_cnt++;
                if (par_cnt >= 8) begin
                    par_cnt = '0;
                    if (!par_sig_ok) begin
                        par_halted = 1'b1;
                        rep = make_report(KIND_OTHER, ST_BAD_SIG, 1'b1, '0);
                        got = 1'b1;
                    end else begin
                        par_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                par_len = {par_len[23:0], b};
                par_cnt++;
                if (par_cnt >= 4) begin
                    par_len[31]    = 1'b0;
                    par_cnt        = '0;
                    par_phase      = PH_TYPE;
                    par_crc        = '1;
                    par_type       = '0;
                    par_stg_fields = '0;
                    par_stg_bytes  = '0;
                end
            end
            PH_TYPE: begin
                par_crc  = crc32_step(par_crc, b);
                par_type = {par_type[23:0], b};
                par_cnt++;
                if (par_cnt >= 4) begin
                    par_cnt    = '0;
                    par_rx_crc = '0;
                    par_phase  = (par_len != 0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA: begin
                par_crc = crc32_step(par_crc, b);
                if (par_type == T_IHDR) begin
                    if (par_cnt < 8)
                        par_stg_fields |= 64'(b) << (56 - 8 * par_cnt);
                    else if (par_cnt < 13)
                        par_stg_bytes |= 40'(b) << (32 - 8 * (par_cnt - 8));
                end
                par_cnt++;
                if (par_cnt >= par_len) begin
                    par_cnt   = '0;
                    par_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                par_rx_crc = {par_rx_crc[23:0], b};
                par_cnt++;
                if (par_cnt >= 4) begin
                    crc_ok = (~par_crc == par_rx_crc);
                    k      = chunk_kind_of(par_type);
                    crit   = (k == KIND_OTHER) && !par_type[29];
                    st     = crit ? ST_UNK_CRIT : (crc_ok ? ST_OK : ST_CRC_ERR);
                    if (k == KIND_IHDR && crc_ok) begin
                        par_hdr_fields = par_stg_fields;
                        par_hdr_bytes  = par_stg_bytes;
                    end
                    par_halted = crit || (k == KIND_IEND);
                    rep        = make_report(k, st, par_halted, par_len[30:0]);
                    got        = 1'b1;
                    par_phase  = PH_LEN;
                    par_cnt    = '0;
                    par_len    = '0;
                end
            end
            default: begin
                par_phase = PH_LEN;
                par_cnt   = '0;
            end
        endcase
    endtask

    // offer one byte; the typed report, if given, replaces the predicted one
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_chunk_report want = '0);
        bit            got;
        t_chunk_report rep;
        if (n_bytes_sent < 420) begin
            snd_idle_pct = 14;
            rcv_idle_pct = 67;
        end else if (n_bytes_sent < 840) begin
            snd_idle_pct = 67;
            rcv_idle_pct = 14;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        if (n_bytes_sent == 900)
            pressure_req = 1'b1;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        n_bytes_sent++;
        parse_byte(b, got, rep);
        if (typed)
            pending_reports.push_back(want);
        else if (got)
            pending_reports.push_back(rep);
    endtask

    task automatic send_chunk(input logic [31:0] ctype, input int dlen, input bit len_top,
                              input bit crc_bad);
        logic [31:0] lw;
        logic [31:0] crc;
        logic [7:0]  d;
        lw  = {len_top, 31'(dlen)};
        crc = '1;
        for (int k = 3; k >= 0; k--)
            send_byte(lw[8*k +: 8]);
        for (int k = 3; k >= 0; k--) begin
            crc = crc32_step(crc, ctype[8*k +: 8]);
            send_byte(ctype[8*k +: 8]);
        end
        for (int i = 0; i < dlen; i++) begin
            d   = 8'($urandom_range(0, 255));
            crc = crc32_step(crc, d);
            send_byte(d);
        end
        crc = ~crc;
        if (crc_bad)
            crc ^= 32'd1 << $urandom_range(0, 31);
        for (int k = 3; k >= 0; k--)
            send_byte(crc[8*k +: 8]);
    endtask

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                hold_left    = 400;
                pressure_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_chunk_report seen;
        t_chunk_report want;
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_chunk_kind, o_status, o_stream_done, o_chunk_length, o_image_width,
                    o_image_height, o_bit_depth, o_color_type, o_compression_method,
                    o_filter_method, o_interlace_method};
            if (pending_reports.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_SHOWN)
                    $display("unexpected report: %s", fmt_report(seen));
            end else begin
                want = pending_reports.pop_front();
                if (seen != want) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN) begin
                        $display("mismatch expected: %s", fmt_report(want));
                        $display("mismatch actual:   %s", fmt_report(seen));
                    end
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          r;
        int          dlen;
        logic [31:0] ctype;
        bit          top;
        bit          bad;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= '0;
        n_bytes_sent = 0;
        n_fail       = 0;
        hold_left    = 0;
        pressure_req = 1'b0;
        snd_idle_pct = 14;
        rcv_idle_pct = 67;
        parse_reset();

        for (int i = 0; i < DIR_N; i++) begin
            dir_rows[i].b     = (i < 8) ? PNG_SIG[i] : DIR_TAIL[i - 8];
            dir_rows[i].typed = 1'b0;
            dir_rows[i].rep   = '0;
        end
        // nothing captured yet, so every header field reads zero
        dir_rows[DIR_N-1].typed       = 1'b1;
        dir_rows[DIR_N-1].rep.kind    = KIND_OTHER;
        dir_rows[DIR_N-1].rep.status  = ST_CRC_ERR;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].rep);

        while (n_bytes_sent < RAND_BYTES) begin
            r   = $urandom_range(0, 99);
            top = ($urandom_range(0, 9) == 0);
            bad = ($urandom_range(0, 99) < 12);
            if (r < 15) begin
                ctype = T_IHDR;
                dlen  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : 13;
            end else if (r < 55) begin
                case ($urandom_range(0, 4))
                    0:       ctype = T_BKGD;
                    1:       ctype = T_PHYS;
                    2:       ctype = T_TIME;
                    3:       ctype = T_ITXT;
                    default: ctype = T_IDAT;
                endcase
                dlen = $urandom_range(0, 24);
            end else if (r < 85) begin
                ctype     = $urandom();
                ctype[29] = 1'b1;   // ancillary, parsing goes on
                dlen      = $urandom_range(0, 16);
            end else begin
                ctype = T_IDAT;
                dlen  = $urandom_range(0, 60);
            end
            send_chunk(ctype, dlen, top, bad);
        end

        // stream ends on IEND or on an unknown critical chunk
        if ($urandom_range(0, 1) == 1) begin
            send_chunk(T_IEND, 0, 1'b0, $urandom_range(0, 3) == 0);
        end else begin
            ctype     = $urandom();
            ctype[29] = 1'b0;
            if (ctype[31:24] == 8'h49)
                ctype[31:24] = 8'h50;
            send_chunk(ctype, $urandom_range(0, 10), 1'b0, $urandom_range(0, 1) == 1);
        end
        // bytes after the halt must be swallowed silently
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom_range(0, 255)));
        i_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
